FILE: rtl/prid_pkg.sv
// ----------------------------------------------------------------------------
// prid_pkg
// Shared types and constants for the palette run-length icon decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package prid_pkg;

  localparam int unsigned COL_W   = 10;  // column and x position
  localparam int unsigned ROW_W   = 10;  // icon row counter
  localparam int unsigned SROW_W  = 12;  // surface row
  localparam int unsigned LEN_W   = 8;   // run length
  localparam int unsigned CH_W    = 6;   // palette channel as stored
  localparam int unsigned PAL_W   = 3 * CH_W;
  localparam int unsigned COLOR_W = 8;   // channel as delivered
  localparam int unsigned CFG_AW  = 2;
  localparam int unsigned CFG_DW  = 12;
  localparam int unsigned IN_DW   = 40;
  localparam int unsigned OUT_DW  = 56;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_X_ORIGIN  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_FIRST_ROW = 2'd1;
  localparam logic [CFG_AW-1:0] REG_LAST_ROW  = 2'd2;
  localparam logic [CFG_AW-1:0] REG_BASE_ROW  = 2'd3;

  // input item kinds
  localparam logic FUNC_IMAGE   = 1'b0;
  localparam logic FUNC_PALETTE = 1'b1;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_COLOR = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  // one result on its way from the decoder to the output stage
  typedef struct packed {
    kind_t              kind;
    logic [COL_W-1:0]   x_start;
    logic [SROW_W-1:0]  out_row;
    logic [LEN_W-1:0]   run_length;
    logic               pal_ok;   // take colour from the palette read
  } run_t;

endpackage : prid_pkg

`default_nettype wire

FILE: rtl/prid_pal_mem.sv
// ----------------------------------------------------------------------------
// prid_pal_mem
// Palette store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module prid_pal_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 18
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : prid_pal_mem

`default_nettype wire

FILE: rtl/prid_ctrl.sv
// ----------------------------------------------------------------------------
// prid_ctrl
// Byte decoder: configuration registers, phase, column and row tracking.
// Produces at most one run or done result per accepted image byte.
// ----------------------------------------------------------------------------
`default_nettype none

module prid_ctrl #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [prid_pkg::CFG_AW-1:0]    cfg_addr,
  input  wire logic [prid_pkg::CFG_DW-1:0]    cfg_wdata,
  input  wire logic                           byte_acc,
  input  wire logic [7:0]                     data_byte,
  output logic                                res_valid,
  output prid_pkg::run_t                      res
);

  import prid_pkg::*;

  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_TLEN = 2'd1,
    PH_FILL = 2'd2,
    PH_LIT  = 2'd3
  } phase_t;

  phase_t             phase_r,    phase_nxt;
  logic [6:0]         lit_left_r, lit_left_nxt;
  logic [COL_W-1:0]   column_r,   column_nxt;
  logic [ROW_W-1:0]   cur_row_r,  cur_row_nxt;
  logic               finished_r, finished_nxt;
  logic [COL_W-1:0]   x_origin_r;
  logic [ROW_W-1:0]   last_row_r;
  logic [SROW_W-1:0]  base_row_r;

  logic [6:0]         count;
  logic               flag;
  logic               idx_ok;
  logic [COL_W-1:0]   run_x;
  logic [SROW_W-1:0]  run_row;

  assign count   = data_byte[7:1];
  assign flag    = data_byte[0];
  assign idx_ok  = ({1'b0, data_byte} < 9'(PALETTE_ENTRIES));
  assign run_x   = column_r + x_origin_r;
  assign run_row = base_row_r + {{(SROW_W-ROW_W){1'b0}}, cur_row_r};

  always_comb begin
    phase_nxt    = phase_r;
    lit_left_nxt = lit_left_r;
    column_nxt   = column_r;
    cur_row_nxt  = cur_row_r;
    finished_nxt = finished_r;
    res_valid    = 1'b0;
    res.kind       = KIND_DONE;
    res.x_start    = '0;
    res.out_row    = '0;
    res.run_length = '0;
    res.pal_ok     = 1'b0;

    if (byte_acc && !finished_r) begin
      if (cur_row_r > last_row_r) begin
        finished_nxt = 1'b1;
        res_valid    = 1'b1;
      end else begin
        case (phase_r)
          PH_CTRL: begin
            if (count == 7'd0 && flag) begin
              phase_nxt = PH_TLEN;
            end else if (count == 7'd0) begin
              // end of row
              column_nxt = '0;
              if (cur_row_r >= last_row_r) begin
                finished_nxt = 1'b1;
                res_valid    = 1'b1;
              end else begin
                cur_row_nxt = cur_row_r + ROW_W'(1);
              end
            end else begin
              lit_left_nxt = count;
              phase_nxt    = flag ? PH_LIT : PH_FILL;
            end
          end
          PH_TLEN: begin
            res_valid      = 1'b1;
            res.kind       = KIND_CLEAR;
            res.x_start    = run_x;
            res.out_row    = run_row;
            res.run_length = data_byte;
            column_nxt     = column_r + {{(COL_W-LEN_W){1'b0}}, data_byte};
            phase_nxt      = PH_CTRL;
          end
          PH_FILL: begin
            res_valid      = 1'b1;
            res.kind       = KIND_COLOR;
            res.x_start    = run_x;
            res.out_row    = run_row;
            res.run_length = {1'b0, lit_left_r};
            res.pal_ok     = idx_ok;
            column_nxt     = column_r + {{(COL_W-7){1'b0}}, lit_left_r};
            lit_left_nxt   = '0;
            phase_nxt      = PH_CTRL;
          end
          PH_LIT: begin
            res_valid      = 1'b1;
            res.kind       = KIND_COLOR;
            res.x_start    = run_x;
            res.out_row    = run_row;
            res.run_length = LEN_W'(1);
            res.pal_ok     = idx_ok;
            column_nxt     = column_r + COL_W'(1);
            lit_left_nxt   = lit_left_r - 7'd1;
            if (lit_left_r == 7'd1) begin
              phase_nxt = PH_CTRL;
            end
          end
          default: begin
            phase_nxt = PH_CTRL;
          end
        endcase
      end
    end

    // a first_row write restarts the image and seeds the row counter
    if (cfg_we && cfg_addr == REG_FIRST_ROW) begin
      phase_nxt    = PH_CTRL;
      lit_left_nxt = '0;
      column_nxt   = '0;
      cur_row_nxt  = cfg_wdata[ROW_W-1:0];
      finished_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CTRL;
      lit_left_r  <= '0;
      column_r    <= '0;
      cur_row_r   <= '0;
      finished_r  <= 1'b0;
      x_origin_r  <= '0;
      last_row_r  <= '0;
      base_row_r  <= '0;
    end else begin
      phase_r    <= phase_nxt;
      lit_left_r <= lit_left_nxt;
      column_r   <= column_nxt;
      cur_row_r  <= cur_row_nxt;
      finished_r <= finished_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_X_ORIGIN:  x_origin_r  <= cfg_wdata[COL_W-1:0];
          REG_LAST_ROW:  last_row_r  <= cfg_wdata[ROW_W-1:0];
          REG_BASE_ROW:  base_row_r  <= cfg_wdata[SROW_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule : prid_ctrl

`default_nettype wire

FILE: rtl/prid_out.sv
// ----------------------------------------------------------------------------
// prid_out
// Result path: a stage that waits for the palette read, then the output
// register. Merges colour into coloured runs.
// ----------------------------------------------------------------------------
`default_nettype none

module prid_out (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  output logic                               slot_ready,
  input  wire logic                          res_valid,
  input  wire prid_pkg::run_t                res,
  input  wire logic [prid_pkg::PAL_W-1:0]    pal_rdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [prid_pkg::OUT_DW-1:0]        out_tdata,
  output logic [1:0]                         out_tuser
);

  import prid_pkg::*;

  logic               s1_valid_r;
  run_t               s1_run_r;
  logic               out_valid_r;
  logic [OUT_DW-1:0]  out_data_r;
  kind_t              out_kind_r;
  logic               s1_adv;

  logic [COLOR_W-1:0] red, green, blue;

  assign s1_adv     = !out_valid_r || out_tready;
  assign slot_ready = !s1_valid_r || s1_adv;

  // palette channels scale by four; transparent and done words carry black
  assign red   = s1_run_r.pal_ok ? {pal_rdata[3*CH_W-1:2*CH_W], 2'b00} : '0;
  assign green = s1_run_r.pal_ok ? {pal_rdata[2*CH_W-1:CH_W], 2'b00} : '0;
  assign blue  = s1_run_r.pal_ok ? {pal_rdata[CH_W-1:0], 2'b00} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (slot_ready) begin
        s1_valid_r <= res_valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_ready && res_valid) begin
      s1_run_r <= res;
    end
    if (s1_adv && s1_valid_r) begin
      out_kind_r <= s1_run_r.kind;
      out_data_r <= {2'b00, blue, green, red, s1_run_r.run_length,
                     s1_run_r.out_row, s1_run_r.x_start};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

endmodule : prid_out

`default_nettype wire

FILE: rtl/palette_rle_icon_decoder.sv
// ----------------------------------------------------------------------------
// palette_rle_icon_decoder
// Run-length palette image decoder with palette write port.
// ----------------------------------------------------------------------------
// Path: a result word passes the palette-wait stage, then the output register.
// Throughput: one input word per cycle unless out_tready stalls; the palette
// read port is used once per image byte, its data taken as the result moves on.
// Reset: clears decoder state and registers; the palette is not cleared and
// must be written before it is read. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_rle_icon_decoder #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [prid_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [prid_pkg::CFG_DW-1:0]   cfg_wdata,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // data_byte, pal_index, pal_red, pal_green, pal_blue (low to high), zero pad
  input  wire logic [prid_pkg::IN_DW-1:0]    in_tdata,
  // func
  input  wire logic                          in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // x_start, out_row, run_length, red, green, blue (low to high), zero pad
  output logic [prid_pkg::OUT_DW-1:0]        out_tdata,
  // kind
  output logic [1:0]                         out_tuser
);

  import prid_pkg::*;

  localparam int unsigned PAL_AW = $clog2(PALETTE_ENTRIES);

  logic              in_acc;
  logic              byte_acc;
  logic              pal_we;
  logic [7:0]        data_byte;
  logic [7:0]        pal_index;
  logic [PAL_W-1:0]  pal_wdata;
  logic [PAL_W-1:0]  pal_rdata;
  logic              res_valid;
  run_t              res;
  logic              slot_ready;

  assign data_byte = in_tdata[7:0];
  assign pal_index = in_tdata[15:8];
  assign pal_wdata = {in_tdata[21:16], in_tdata[27:22], in_tdata[33:28]};

  assign in_tready = slot_ready;
  assign in_acc    = in_tvalid && slot_ready;
  assign byte_acc  = in_acc && (in_tuser == FUNC_IMAGE);
  // drop writes past the end of the palette
  assign pal_we    = in_acc && (in_tuser == FUNC_PALETTE) &&
                     ({1'b0, pal_index} < 9'(PALETTE_ENTRIES));

  prid_pal_mem #(
    .DEPTH (PALETTE_ENTRIES),
    .AW    (PAL_AW),
    .DW    (PAL_W)
  ) u_pal (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_index[PAL_AW-1:0]),
    .wdata (pal_wdata),
    .re    (byte_acc),
    .raddr (data_byte[PAL_AW-1:0]),
    .rdata (pal_rdata)
  );

  prid_ctrl #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .byte_acc  (byte_acc),
    .data_byte (data_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  prid_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .slot_ready (slot_ready),
    .res_valid  (res_valid),
    .res        (res),
    .pal_rdata  (pal_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule : palette_rle_icon_decoder

`default_nettype wire
